FILE: rtl/ags_pkg.sv
// shared types, constants and joining-table functions for the arabic glyph shaper
package ags_pkg;

  localparam int CODE_W        = 21;
  localparam int MAX_MARKS_DEF = 8;
  localparam int CMD_DEPTH     = 2;
  localparam int CMD_PTR_W     = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int CMD_CNT_W     = $clog2(CMD_DEPTH + 1);

  localparam logic [CODE_W-1:0] MARK_A_LO = CODE_W'(32'h064b);
  localparam logic [CODE_W-1:0] MARK_A_HI = CODE_W'(32'h0655);
  localparam logic [CODE_W-1:0] MARK_B_LO = CODE_W'(32'hfc5e);
  localparam logic [CODE_W-1:0] MARK_B_HI = CODE_W'(32'hfc63);
  localparam logic [CODE_W-1:0] MARK_ALEF = CODE_W'(32'h0670);
  localparam logic [CODE_W-1:0] NO_CODE   = '0;

  typedef struct packed {
    logic [CODE_W-1:0] code_in;
    logic              end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [CODE_W-1:0] code_out;
    logic              last_of_run;
    logic              text_end;
  } out_item_t;

  // one classified item waiting between front and back
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              eot;
    logic              mark;
  } cmd_t;

  typedef struct packed {
    logic        hit;
    logic [15:0] ini;
    logic [15:0] med;
    logic [15:0] fin;
  } join_t;

  function automatic logic is_mark(input logic [CODE_W-1:0] c);
    is_mark = (c >= MARK_A_LO && c <= MARK_A_HI) ||
              (c >= MARK_B_LO && c <= MARK_B_HI) || (c == MARK_ALEF);
  endfunction

  function automatic join_t join_lookup(input logic [CODE_W-1:0] c);
    join_t e;
    e = '{hit: 1'b1, ini: 16'h0, med: 16'h0, fin: 16'h0};
    case (c)
      21'h0621: e.fin = 16'h0;
      21'h0622: e.fin = 16'hfe82;
      21'h0623: e.fin = 16'hfe84;
      21'h0624: e.fin = 16'hfe86;
      21'h0625: e.fin = 16'hfe88;
      21'h0626: e = '{1'b1, 16'hfe8b, 16'hfe8c, 16'hfe8a};
      21'h0627: e.fin = 16'hfe8e;
      21'h0628: e = '{1'b1, 16'hfe91, 16'hfe92, 16'hfe90};
      21'h0629: e.fin = 16'hfe94;
      21'h062a: e = '{1'b1, 16'hfe97, 16'hfe98, 16'hfe96};
      21'h062b: e = '{1'b1, 16'hfe9b, 16'hfe9c, 16'hfe9a};
      21'h062c: e = '{1'b1, 16'hfe9f, 16'hfea0, 16'hfe9e};
      21'h062d: e = '{1'b1, 16'hfea3, 16'hfea4, 16'hfea2};
      21'h062e: e = '{1'b1, 16'hfea7, 16'hfea8, 16'hfea6};
      21'h062f: e.fin = 16'hfeaa;
      21'h0630: e.fin = 16'hfeac;
      21'h0631: e.fin = 16'hfeae;
      21'h0632: e.fin = 16'hfeb0;
      21'h0633: e = '{1'b1, 16'hfeb3, 16'hfeb4, 16'hfeb2};
      21'h0634: e = '{1'b1, 16'hfeb7, 16'hfeb8, 16'hfeb6};
      21'h0635: e = '{1'b1, 16'hfebb, 16'hfebc, 16'hfeba};
      21'h0636: e = '{1'b1, 16'hfebf, 16'hfec0, 16'hfebe};
      21'h0637: e = '{1'b1, 16'hfec3, 16'hfec4, 16'hfec2};
      21'h0638: e = '{1'b1, 16'hfec7, 16'hfec8, 16'hfec6};
      21'h0639: e = '{1'b1, 16'hfecb, 16'hfecc, 16'hfeca};
      21'h063a: e = '{1'b1, 16'hfecf, 16'hfed0, 16'hfece};
      21'h0640: e = '{1'b1, 16'h0640, 16'h0640, 16'h0};
      21'h0641: e = '{1'b1, 16'hfed3, 16'hfed4, 16'hfed2};
      21'h0642: e = '{1'b1, 16'hfed7, 16'hfed8, 16'hfed6};
      21'h0643: e = '{1'b1, 16'hfedb, 16'hfedc, 16'hfeda};
      21'h0644: e = '{1'b1, 16'hfedf, 16'hfee0, 16'hfede};
      21'h0645: e = '{1'b1, 16'hfee3, 16'hfee4, 16'hfee2};
      21'h0646: e = '{1'b1, 16'hfee7, 16'hfee8, 16'hfee6};
      21'h0647: e = '{1'b1, 16'hfeeb, 16'hfeec, 16'hfeea};
      21'h0648: e.fin = 16'hfeee;
      21'h0649: e.fin = 16'hfef0;
      21'h064a: e = '{1'b1, 16'hfef3, 16'hfef4, 16'hfef2};
      21'h067e: e = '{1'b1, 16'hfb58, 16'hfb59, 16'hfb57};
      21'h0686: e = '{1'b1, 16'hfb7c, 16'hfb7d, 16'hfb7b};
      21'h0698: e.fin = 16'hfb8b;
      21'h06a9: e = '{1'b1, 16'hfb90, 16'hfb91, 16'hfb8f};
      21'h06af: e = '{1'b1, 16'hfb94, 16'hfb95, 16'hfb93};
      21'h06cc: e = '{1'b1, 16'hfbfe, 16'hfbff, 16'hfbfd};
      21'h200c: e.fin = 16'h0;
      21'h200d: e = '{1'b1, 16'h200d, 16'h200d, 16'h0};
      default:  e.hit = 1'b0;
    endcase
    return e;
  endfunction

  // joins towards the following character
  function automatic logic joins_next(input join_t e);
    joins_next = e.hit && ((e.ini != 16'h0) || (e.med != 16'h0));
  endfunction

  // joins towards the preceding character
  function automatic logic joins_prev(input join_t e);
    joins_prev = e.hit && ((e.fin != 16'h0) || (e.med != 16'h0));
  endfunction

  function automatic logic [CODE_W-1:0] shape(input logic [CODE_W-1:0] cur,
                                              input logic [CODE_W-1:0] prior,
                                              input logic [CODE_W-1:0] after);
    join_t       e;
    join_t       b;
    join_t       a;
    logic        jp;
    logic        jn;
    logic [15:0] form;
    e  = join_lookup(cur);
    b  = join_lookup(prior);
    a  = join_lookup(after);
    jp = joins_next(b) && joins_prev(e);
    jn = joins_next(e) && joins_prev(a);
    if (jp && jn) begin
      form = e.med;
    end else if (jp) begin
      form = e.fin;
    end else if (jn) begin
      form = e.ini;
    end else begin
      form = 16'h0;
    end
    // isolated, missing form or non-table character keeps its own code
    if (!e.hit || form == 16'h0) begin
      return cur;
    end
    return {{(CODE_W-16){1'b0}}, form};
  endfunction

endpackage

FILE: rtl/ags_front.sv
// front end: takes items in, classifies marks and queues them for the back end
module ags_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_push,
  output logic          in_full,
  input  ags_pkg::in_item_t in_item,
  output logic          cmd_valid,
  output ags_pkg::cmd_t cmd,
  input  logic          cmd_take
);
  import ags_pkg::*;

  cmd_t                 entries_r [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CMD_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CMD_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 push_ok;
  logic                 pop_ok;
  cmd_t                 new_cmd;

  assign in_full   = (cnt_r == CMD_CNT_W'(CMD_DEPTH));
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = entries_r[rd_ptr_r];
  assign push_ok   = in_push && !in_full;
  assign pop_ok    = cmd_take && cmd_valid;

  always_comb begin
    new_cmd.code = in_item.code_in;
    new_cmd.eot  = in_item.end_of_text;
    new_cmd.mark = is_mark(in_item.code_in);
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push_ok) begin
      wr_ptr_nxt = (wr_ptr_r == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_ok) begin
      rd_ptr_nxt = (rd_ptr_r == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push_ok && !pop_ok) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop_ok && !push_ok) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      entries_r[wr_ptr_r] <= new_cmd;
    end
  end

endmodule

FILE: rtl/ags_back.sv
// back end: holds base and marks, shapes, emits at most one result a cycle
module ags_back #(
  parameter int MAX_MARKS = ags_pkg::MAX_MARKS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  input  ags_pkg::cmd_t      cmd,
  output logic               cmd_take,
  output logic               out_empty,
  input  logic               out_pop,
  output ags_pkg::out_item_t out_item
);
  import ags_pkg::*;

  localparam int CNT_W = $clog2(MAX_MARKS + 1);
  localparam int IDX_W = (MAX_MARKS > 1) ? $clog2(MAX_MARKS) : 1;

  typedef enum logic [1:0] {ST_IDLE, ST_BASE, ST_MARKS, ST_PUTC} state_t;
  // what follows once the held base and its marks are out
  typedef enum logic [1:0] {CONT_NONE, CONT_PUT, CONT_HOLD} cont_t;

  state_t            state_r, state_nxt;
  cont_t             cont_r, cont_nxt;
  logic [CODE_W-1:0] prior_r, prior_nxt;
  logic [CODE_W-1:0] held_r, held_nxt;
  logic              held_valid_r, held_valid_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [CODE_W-1:0] after_r, after_nxt;
  logic [CODE_W-1:0] cur_code_r, cur_code_nxt;
  logic              cur_eot_r, cur_eot_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_item_r, out_item_nxt;

  logic [CODE_W-1:0] marks_r [MAX_MARKS];
  logic              mark_we;

  logic              can_emit;
  logic              emit;
  logic [CODE_W-1:0] emit_code;
  logic              emit_last;
  logic              emit_eot;
  logic              flush_done;
  logic              flush_tail_last;

  assign can_emit        = !out_valid_r || out_pop;
  assign out_empty       = !out_valid_r;
  assign out_item        = out_item_r;
  assign flush_tail_last = (cont_r == CONT_NONE) || (cont_r == CONT_HOLD && !cur_eot_r);

  always_comb begin
    state_nxt      = state_r;
    cont_nxt       = cont_r;
    prior_nxt      = prior_r;
    held_nxt       = held_r;
    held_valid_nxt = held_valid_r;
    cnt_nxt        = cnt_r;
    idx_nxt        = idx_r;
    after_nxt      = after_r;
    cur_code_nxt   = cur_code_r;
    cur_eot_nxt    = cur_eot_r;
    cmd_take       = 1'b0;
    mark_we        = 1'b0;
    emit           = 1'b0;
    emit_code      = cur_code_r;
    emit_last      = 1'b0;
    emit_eot       = cur_eot_r;
    flush_done     = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          cur_code_nxt = cmd.code;
          cur_eot_nxt  = cmd.eot;
          idx_nxt      = '0;
          if (cmd.mark && !held_valid_r) begin
            // lone mark goes straight out
            if (can_emit) begin
              cmd_take  = 1'b1;
              emit      = 1'b1;
              emit_code = cmd.code;
              emit_last = 1'b1;
              emit_eot  = cmd.eot;
              if (cmd.eot) begin
                prior_nxt = NO_CODE;
              end
            end
          end else if (cmd.mark && cnt_r < CNT_W'(MAX_MARKS)) begin
            cmd_take = 1'b1;
            mark_we  = 1'b1;
            cnt_nxt  = cnt_r + 1'b1;
            if (cmd.eot) begin
              state_nxt = ST_BASE;
              after_nxt = NO_CODE;
              cont_nxt  = CONT_NONE;
            end
          end else if (cmd.mark) begin
            // store overflow: resolve the held base as at end of line
            cmd_take  = 1'b1;
            state_nxt = ST_BASE;
            after_nxt = NO_CODE;
            cont_nxt  = CONT_PUT;
          end else if (held_valid_r) begin
            cmd_take  = 1'b1;
            state_nxt = ST_BASE;
            after_nxt = cmd.code;
            cont_nxt  = CONT_HOLD;
          end else begin
            cmd_take       = 1'b1;
            held_nxt       = cmd.code;
            held_valid_nxt = 1'b1;
            cnt_nxt        = '0;
            if (cmd.eot) begin
              state_nxt = ST_BASE;
              after_nxt = NO_CODE;
              cont_nxt  = CONT_NONE;
            end
          end
        end
      end
      ST_BASE: begin
        if (can_emit) begin
          emit      = 1'b1;
          emit_code = shape(held_r, prior_r, after_r);
          if (cnt_r == '0) begin
            flush_done = 1'b1;
            emit_last  = flush_tail_last;
          end else begin
            state_nxt = ST_MARKS;
          end
        end
      end
      ST_MARKS: begin
        if (can_emit) begin
          emit      = 1'b1;
          emit_code = marks_r[idx_r[IDX_W-1:0]];
          if (idx_r + 1'b1 == cnt_r) begin
            flush_done = 1'b1;
            emit_last  = flush_tail_last;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      ST_PUTC: begin
        if (can_emit) begin
          emit      = 1'b1;
          emit_code = cur_code_r;
          emit_last = 1'b1;
          state_nxt = ST_IDLE;
          if (cur_eot_r) begin
            prior_nxt = NO_CODE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (flush_done) begin
      prior_nxt      = held_r;
      held_valid_nxt = 1'b0;
      cnt_nxt        = '0;
      idx_nxt        = '0;
      case (cont_r)
        CONT_PUT: begin
          state_nxt = ST_PUTC;
        end
        CONT_HOLD: begin
          held_nxt       = cur_code_r;
          held_valid_nxt = 1'b1;
          if (cur_eot_r) begin
            state_nxt = ST_BASE;
            after_nxt = NO_CODE;
            cont_nxt  = CONT_NONE;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
        default: begin
          state_nxt = ST_IDLE;
          if (cur_eot_r) begin
            prior_nxt = NO_CODE;
          end
        end
      endcase
    end

    out_valid_nxt = out_valid_r && !out_pop;
    out_item_nxt  = out_item_r;
    if (emit) begin
      out_valid_nxt         = 1'b1;
      out_item_nxt.code_out = emit_code;
      out_item_nxt.last_of_run = emit_last;
      out_item_nxt.text_end = emit_last && emit_eot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cont_r       <= CONT_NONE;
      prior_r      <= '0;
      held_r       <= '0;
      held_valid_r <= 1'b0;
      cnt_r        <= '0;
      idx_r        <= '0;
      after_r      <= '0;
      cur_code_r   <= '0;
      cur_eot_r    <= 1'b0;
      out_valid_r  <= 1'b0;
      out_item_r   <= '0;
    end else begin
      state_r      <= state_nxt;
      cont_r       <= cont_nxt;
      prior_r      <= prior_nxt;
      held_r       <= held_nxt;
      held_valid_r <= held_valid_nxt;
      cnt_r        <= cnt_nxt;
      idx_r        <= idx_nxt;
      after_r      <= after_nxt;
      cur_code_r   <= cur_code_nxt;
      cur_eot_r    <= cur_eot_nxt;
      out_valid_r  <= out_valid_nxt;
      out_item_r   <= out_item_nxt;
    end
  end

  // mark store, read only below the fill count so no reset is needed
  always_ff @(posedge clk) begin
    if (mark_we) begin
      marks_r[cnt_r[IDX_W-1:0]] <= cmd.code;
    end
  end

endmodule

FILE: rtl/arabic_glyph_shaper.sv
// arabic contextual shaper top level: classifying front end, queue, shaping back end
// a mark with no base held is taken and put out directly; a base is shaped only once
//   the next base, a store overflow or the end of text shows what follows it
// the back end takes no new item while it puts out a held base and its marks
// the front queue holds two items, so input is still taken while results drain
// reset: synchronous active-low rst_n clears queue, held base and output register
module arabic_glyph_shaper #(
  parameter int MAX_MARKS = ags_pkg::MAX_MARKS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  ags_pkg::in_item_t  in_item,
  output logic               out_empty,
  input  logic               out_pop,
  output ags_pkg::out_item_t out_item
);
  import ags_pkg::*;

  logic cmd_valid;
  logic cmd_take;
  cmd_t cmd;

  ags_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  ags_back #(
    .MAX_MARKS (MAX_MARKS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule
